>>> design/scene_text_tokenizer_macros.svh
// assertion macros used by the tokenizer top level
`ifndef SCENE_TEXT_TOKENIZER_MACROS_SVH
`define SCENE_TEXT_TOKENIZER_MACROS_SVH

// same-cycle implication, checked out of reset
`define STT_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/stt_pkg.sv
`default_nettype none

package stt_pkg;

	localparam int POSITION_BITS = 32;
	localparam int LENGTH_BITS = 16;
	localparam int KIND_BITS = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_UNDER = 8'h5f;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_INT     = 3'd2,
		MODE_FRAC    = 3'd3,
		MODE_STRING  = 3'd4,
		MODE_COMMENT = 3'd5,
		MODE_POINT   = 3'd6,
		MODE_DRAIN   = 3'd7
	} mode_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_IDENT   = 4'd0,
		KIND_NUMBER  = 4'd1,
		KIND_STRING  = 4'd2,
		KIND_COMMENT = 4'd3,
		KIND_LEFT    = 4'd4,
		KIND_RIGHT   = 4'd5,
		KIND_NEWLINE = 4'd6,
		KIND_EOF     = 4'd7,
		KIND_ERROR   = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [POSITION_BITS-1:0] start;
		logic [LENGTH_BITS-1:0]   length;
	} report_t;

	// all reports caused by one byte; rep1 only counts when two is set
	typedef struct packed {
		report_t rep0;
		report_t rep1;
		logic    two;
	} entry_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5a)) || ((b >= 8'h61) && (b <= 8'h7a));
	endfunction

	function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] x);
		return (x == LEN_MAX) ? x : x + LEN_ONE;
	endfunction

endpackage

`default_nettype wire

>>> design/scene_text_tokenizer.sv
`default_nettype none

// Scene text tokenizer. Takes one byte of scene text per transfer on the
// input channel (zero byte = end of file) and reports every finished token
// as kind, start offset and saturating length on the output channel. One
// byte is taken every cycle as long as the four-entry report queue between
// the front end and the output stage has room. A byte that closes an
// identifier, number or comment and also makes a report of its own gives
// two reports; the output stage sends one report per cycle unless the
// output is stalled, and the queue absorbs short bursts of such bytes. A
// report passes a queue slot and then the output register. After an error
// report not made by a zero byte, bytes are swallowed up to and including
// the next zero byte. Offsets count every byte since reset and wrap.

`include "scene_text_tokenizer_macros.svh"

module scene_text_tokenizer import stt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          text_byte,
	// output channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [KIND_BITS-1:0]     token_kind,
	output logic [POSITION_BITS-1:0] token_start,
	output logic [LENGTH_BITS-1:0]   token_length,
	output logic                     last_of_run
);

	// front end to queue
	logic   push;
	entry_t push_entry;
	logic   queue_full;

	// queue to output stage
	entry_t head_entry;
	logic   queue_empty;
	logic   pop;

	// the front end stalls only when the queue has no free entry
	assign in_stall = queue_full;

	// byte classification and token state machine
	stt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.text_byte  (text_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// report queue, one entry per report-producing byte
	stt_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.empty      (queue_empty),
		.full       (queue_full)
	);

	// splits entries into single reports behind an output register
	stt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_entry   (head_entry),
		.empty        (queue_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	// end of file always has zero length
	`STT_ASSERT_IMPLY(a_eof_len, out_valid && token_kind == KIND_EOF, token_length == '0, "eof report with nonzero length")

	// single-byte tokens always have length one
	`STT_ASSERT_IMPLY(a_single_len, out_valid && (token_kind == KIND_LEFT || token_kind == KIND_RIGHT || token_kind == KIND_NEWLINE), token_length == LEN_ONE, "single-byte token with wrong length")

	// an error is never followed by another report of the same byte
	`STT_ASSERT_IMPLY(a_error_last, out_valid && token_kind == KIND_ERROR, last_of_run, "error report not last of its byte")

	// a report of a byte that still has one more is followed by output valid
	`STT_ASSERT_NEXT(a_pair_follows, out_valid && !out_stall && !last_of_run, out_valid, "second report of a byte missing")

endmodule

`default_nettype wire

>>> design/stt_front.sv
`default_nettype none

module stt_front import stt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] text_byte,
	input  wire logic       queue_full,
	output logic            push,
	output entry_t          push_entry
);

	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d;

	logic                     accept;
	logic                     any_report;

	// between-token handling of the current byte
	logic                     id_emit;
	report_t                  id_rep;
	mode_t                    id_mode;
	logic [POSITION_BITS-1:0] id_start;
	logic [LENGTH_BITS-1:0]   id_len;

	assign accept = in_valid && !queue_full;
	assign push = accept && any_report;

	always_comb begin
		id_emit = 1'b0;
		id_rep = '{kind: KIND_EOF, start: pos_q, length: LEN_ZERO};
		id_mode = MODE_IDLE;
		id_start = start_q;
		id_len = len_q;
		priority if (text_byte == CH_SPACE || text_byte == CH_TAB) begin
			id_emit = 1'b0;
		end else if (text_byte == CH_NUL) begin
			id_emit = 1'b1;
		end else if (text_byte == CH_LF) begin
			id_emit = 1'b1;
			id_rep.kind = KIND_NEWLINE;
			id_rep.length = LEN_ONE;
		end else if (text_byte == CH_LBRACK) begin
			id_emit = 1'b1;
			id_rep.kind = KIND_LEFT;
			id_rep.length = LEN_ONE;
		end else if (text_byte == CH_RBRACK) begin
			id_emit = 1'b1;
			id_rep.kind = KIND_RIGHT;
			id_rep.length = LEN_ONE;
		end else if (text_byte == CH_HASH) begin
			id_mode = MODE_COMMENT;
			id_start = pos_q;
			id_len = LEN_ONE;
		end else if (text_byte == CH_QUOTE) begin
			id_mode = MODE_STRING;
			id_start = pos_q + POSITION_BITS'(1);
			id_len = LEN_ZERO;
		end else if (text_byte == CH_POINT) begin
			id_mode = MODE_POINT;
			id_start = pos_q;
			id_len = LEN_ONE;
		end else if (is_digit(text_byte)) begin
			id_mode = MODE_INT;
			id_start = pos_q;
			id_len = LEN_ONE;
		end else if (is_alpha(text_byte) || text_byte == CH_UNDER) begin
			id_mode = MODE_IDENT;
			id_start = pos_q;
			id_len = LEN_ONE;
		end else begin
			// stray byte, never zero here
			id_emit = 1'b1;
			id_rep.kind = KIND_ERROR;
			id_rep.length = LEN_ONE;
			id_mode = MODE_DRAIN;
			id_start = pos_q;
			id_len = LEN_ZERO;
		end
	end

	always_comb begin
		mode_d = mode_q;
		start_d = start_q;
		len_d = len_q;
		any_report = 1'b0;
		push_entry.rep0 = id_rep;
		push_entry.rep1 = id_rep;
		push_entry.two = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				mode_d = id_mode;
				start_d = id_start;
				len_d = id_len;
				any_report = id_emit;
			end
			MODE_IDENT: begin
				if (is_alpha(text_byte) || is_digit(text_byte) || text_byte == CH_UNDER) begin
					len_d = sat_inc(len_q);
				end else begin
					push_entry.rep0 = '{kind: KIND_IDENT, start: start_q, length: len_q};
					push_entry.two = id_emit;
					any_report = 1'b1;
					mode_d = id_mode;
					start_d = id_start;
					len_d = id_len;
				end
			end
			MODE_INT, MODE_FRAC: begin
				priority if (is_digit(text_byte)) begin
					len_d = sat_inc(len_q);
				end else if (text_byte == CH_POINT && mode_q == MODE_INT) begin
					len_d = sat_inc(len_q);
					mode_d = MODE_FRAC;
				end else if (is_alpha(text_byte)) begin
					push_entry.rep0 = '{kind: KIND_ERROR, start: start_q,
						length: sat_inc(len_q)};
					any_report = 1'b1;
					mode_d = MODE_DRAIN;
				end else begin
					push_entry.rep0 = '{kind: KIND_NUMBER, start: start_q, length: len_q};
					push_entry.two = id_emit;
					any_report = 1'b1;
					mode_d = id_mode;
					start_d = id_start;
					len_d = id_len;
				end
			end
			MODE_STRING: begin
				priority if (text_byte == CH_QUOTE) begin
					push_entry.rep0 = '{kind: KIND_STRING, start: start_q, length: len_q};
					any_report = 1'b1;
					mode_d = MODE_IDLE;
				end else if (text_byte == CH_NUL) begin
					push_entry.rep0 = '{kind: KIND_ERROR, start: start_q,
						length: sat_inc(len_q)};
					any_report = 1'b1;
					mode_d = MODE_IDLE;
				end else begin
					len_d = sat_inc(len_q);
				end
			end
			MODE_COMMENT: begin
				if (text_byte == CH_LF || text_byte == CH_NUL) begin
					push_entry.rep0 = '{kind: KIND_COMMENT, start: start_q, length: len_q};
					push_entry.two = id_emit;
					any_report = 1'b1;
					mode_d = id_mode;
					start_d = id_start;
					len_d = id_len;
				end else begin
					len_d = sat_inc(len_q);
				end
			end
			MODE_POINT: begin
				if (is_digit(text_byte)) begin
					len_d = sat_inc(len_q);
					mode_d = MODE_FRAC;
				end else begin
					push_entry.rep0 = '{kind: KIND_ERROR, start: start_q,
						length: sat_inc(len_q)};
					any_report = 1'b1;
					mode_d = (text_byte == CH_NUL) ? MODE_IDLE : MODE_DRAIN;
				end
			end
			MODE_DRAIN: begin
				if (text_byte == CH_NUL) begin
					mode_d = MODE_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			start_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			pos_q <= pos_q + POSITION_BITS'(1);
			start_q <= start_d;
			len_q <= len_d;
		end
	end

endmodule

`default_nettype wire

>>> design/stt_fifo.sv
`default_nettype none

module stt_fifo import stt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head_entry,
	output logic        empty,
	output logic        full
);

	entry_t                    slots_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign head_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_BITS'(1);
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + (QUEUE_PTR_BITS+1)'(1);
				2'b01: count_q <= count_q - (QUEUE_PTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/stt_back.sv
`default_nettype none

module stt_back import stt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire entry_t              head_entry,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [KIND_BITS-1:0]     token_kind,
	output logic [POSITION_BITS-1:0] token_start,
	output logic [LENGTH_BITS-1:0]   token_length,
	output logic                     last_of_run
);

	logic    out_valid_q;
	report_t out_rep_q;
	logic    out_last_q;
	logic    pend_valid_q;
	report_t pend_rep_q;
	logic    load;

	assign load = !out_valid_q || !out_stall;
	assign pop = load && !pend_valid_q && !empty;

	assign out_valid = out_valid_q;
	assign token_kind = out_rep_q.kind;
	assign token_start = out_rep_q.start;
	assign token_length = out_rep_q.length;
	assign last_of_run = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q <= !empty;
				pend_valid_q <= !empty && head_entry.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_rep_q <= pend_rep_q;
				out_last_q <= 1'b1;
			end else if (!empty) begin
				out_rep_q <= head_entry.rep0;
				out_last_q <= !head_entry.two;
				pend_rep_q <= head_entry.rep1;
			end
		end
	end

endmodule

`default_nettype wire
